[src/utsan_pkg.sv]
// Shared types and constants for the UTF-8 text sanitizer.
// No dependencies; used by utsan_step and utf8_text_sanitizer.
package utsan_pkg;

	// one raw message byte
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_end;
	} text_req_t;

	// one sanitized byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       msg_end;
	} clean_req_t;

	localparam int MaxOut  = 4;  // most bytes one input can release
	localparam int HeldMax = 3;  // most bytes held for an open sequence

	// decoder state between input bytes
	typedef struct packed {
		logic [1:0]  held_count;
		logic [2:0]  seq_length;
		logic [20:0] partial_cp;
	} seq_state_t;

	// bytes released by one input, in order from index 0
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [2:0]             count;
	} burst_t;

	// write into the held-byte store
	typedef struct packed {
		logic       en;
		logic [1:0] idx;
	} hold_wr_t;

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChQuest = 8'h3F;
	localparam logic [7:0] ChLt    = 8'h3C;
	localparam logic [7:0] ChGt    = 8'h3E;
	localparam logic [7:0] ChLbr   = 8'h5B;
	localparam logic [7:0] ChRbr   = 8'h5D;
	localparam logic [7:0] ChDel   = 8'h7F;
	localparam logic [7:0] CtlTop  = 8'h20;

	localparam logic [7:0] Lead2Lo = 8'hC2;
	localparam logic [7:0] Lead2Hi = 8'hDF;
	localparam logic [7:0] Lead3Lo = 8'hE0;
	localparam logic [7:0] Lead3Hi = 8'hEF;
	localparam logic [7:0] Lead4Lo = 8'hF0;
	localparam logic [7:0] Lead4Hi = 8'hF4;

	localparam logic [2:0] Len2 = 3'd2;
	localparam logic [2:0] Len3 = 3'd3;
	localparam logic [2:0] Len4 = 3'd4;

	localparam logic [20:0] CpMin3   = 21'h000800;
	localparam logic [20:0] CpMin4   = 21'h010000;
	localparam logic [20:0] CpMax    = 21'h10FFFF;
	localparam logic [20:0] SurLo    = 21'h00D800;
	localparam logic [20:0] SurHi    = 21'h00DFFF;
	localparam logic [20:0] C1Lo     = 21'h000080;
	localparam logic [20:0] C1Hi     = 21'h00009F;
	localparam logic [20:0] LineSep  = 21'h002028;
	localparam logic [20:0] ParaSep  = 21'h002029;

endpackage

[src/utf8_text_sanitizer.sv]
// Top level of the UTF-8 text sanitizer: input register, decode step, output burst buffer.
// Depends on utsan_pkg and utsan_step.
//
// The block takes one message byte per request on the text channel and sends
// the sanitized bytes, one per request, on the clean channel. Each input byte
// releases zero to four output bytes: bytes of an open multi-byte sequence are
// held until it completes, breaks or the message ends, and then go out
// together, as themselves or as '?' or a single space. The last output byte
// of an input carries run_last, and if that input carried in_end it also
// carries msg_end. An input byte is registered, decoded into a burst of up to
// four bytes once the buffer can take it, and the burst is shifted out one
// byte per cycle while the receiver is ready. A burst's first byte is offered
// once its input has passed the input register and the burst buffer. The
// input side takes one byte per clock while each input releases at most one
// byte and the receiver is ready; a larger burst holds the output until it
// has gone, and the input stalls while a burst has more than one byte left.
// Inputs that release nothing leave the output untouched. There is no configuration.
module utf8_text_sanitizer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  utsan_pkg::text_req_t   text_req,
	output logic                   clean_valid,
	input  logic                   clean_ready,
	output utsan_pkg::clean_req_t  clean_req
);

	// input register
	logic                  valid_s1;
	utsan_pkg::text_req_t  req_s1;

	// decoder state
	utsan_pkg::seq_state_t seq_q;
	logic [2:0][7:0]       held_q;

	// output burst buffer, byte 0 is the one on the port
	logic [utsan_pkg::MaxOut-1:0][7:0] buf_q;
	logic [2:0]                        rem_q;
	logic                              end_q;

	utsan_pkg::seq_state_t seq_next;
	utsan_pkg::hold_wr_t   hold_wr;
	utsan_pkg::burst_t     burst;

	logic pop;
	logic buf_free;
	logic advance;

	utsan_step u_step (
		.cur_byte   (req_s1.in_byte),
		.last       (req_s1.in_end),
		.state      (seq_q),
		.held       (held_q),
		.next_state (seq_next),
		.hold_wr    (hold_wr),
		.burst      (burst)
	);

	// buffer can take a new burst once it is empty or its last byte leaves now
	assign pop        = clean_valid && clean_ready;
	assign buf_free   = (rem_q == '0) || (rem_q == 3'd1 && clean_ready);
	assign advance    = valid_s1 && buf_free;
	assign text_ready = !valid_s1 || buf_free;

	assign clean_valid        = (rem_q != '0);
	assign clean_req.out_byte = buf_q[0];
	assign clean_req.run_last = (rem_q == 3'd1);
	assign clean_req.msg_end  = (rem_q == 3'd1) && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			req_s1 <= text_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (advance) begin
			seq_q <= seq_next;
		end
	end

	// held bytes are read only below held_count, so no reset
	always_ff @(posedge clk) begin
		if (advance && hold_wr.en) begin
			held_q[hold_wr.idx] <= req_s1.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (advance && burst.count != '0) begin
			rem_q <= burst.count;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && burst.count != '0) begin
			buf_q <= burst.bytes;
			end_q <= req_s1.in_end;
		end else if (pop) begin
			buf_q <= {8'h00, buf_q[utsan_pkg::MaxOut-1:1]};
		end
	end

endmodule

[src/utsan_step.sv]
// One decoding step of the sanitizer: next sequence state and released bytes.
// Purely combinational. Depends on utsan_pkg.
module utsan_step (
	input  logic [7:0]              cur_byte,
	input  logic                    last,
	input  utsan_pkg::seq_state_t   state,
	input  logic [2:0][7:0]         held,
	output utsan_pkg::seq_state_t   next_state,
	output utsan_pkg::hold_wr_t     hold_wr,
	output utsan_pkg::burst_t       burst
);

	// fresh-byte decode
	logic [7:0]  fresh_byte;
	logic        fresh_out;
	logic [2:0]  fresh_len;
	logic [20:0] fresh_cp;

	// open-sequence path
	logic        in_seq;
	logic        is_cont;
	logic [20:0] cp_new;
	logic [2:0]  cnt;
	logic        complete;
	logic        cp_ok;
	logic        cp_space;

	// output assembly
	logic [1:0]       prefix_n;
	logic             prefix_held;
	logic             tail_en;
	logic [7:0]       tail_byte;
	logic [3:0][7:0]  pre;
	logic             take_fresh;

	always_comb begin
		fresh_len = '0;
		fresh_cp  = '0;
		if (cur_byte >= utsan_pkg::Lead2Lo && cur_byte <= utsan_pkg::Lead2Hi) begin
			fresh_len = utsan_pkg::Len2;
			fresh_cp  = {16'h0000, cur_byte[4:0]};
		end else if (cur_byte >= utsan_pkg::Lead3Lo && cur_byte <= utsan_pkg::Lead3Hi) begin
			fresh_len = utsan_pkg::Len3;
			fresh_cp  = {17'h00000, cur_byte[3:0]};
		end else if (cur_byte >= utsan_pkg::Lead4Lo && cur_byte <= utsan_pkg::Lead4Hi) begin
			fresh_len = utsan_pkg::Len4;
			fresh_cp  = {18'h00000, cur_byte[2:0]};
		end

		fresh_out  = 1'b1;
		fresh_byte = cur_byte;
		if (!cur_byte[7]) begin
			if (cur_byte < utsan_pkg::CtlTop || cur_byte == utsan_pkg::ChDel) begin
				fresh_byte = utsan_pkg::ChSpace;
			end else if (cur_byte == utsan_pkg::ChLt) begin
				fresh_byte = utsan_pkg::ChLbr;
			end else if (cur_byte == utsan_pkg::ChGt) begin
				fresh_byte = utsan_pkg::ChRbr;
			end
		end else if (fresh_len != '0 && !last) begin
			fresh_out = 1'b0;  // lead byte opens a sequence
		end else begin
			fresh_byte = utsan_pkg::ChQuest;
		end
	end

	assign in_seq   = (state.seq_length != '0);
	assign is_cont  = (cur_byte[7:6] == 2'b10);
	assign cp_new   = {state.partial_cp[14:0], cur_byte[5:0]};
	assign cnt      = {1'b0, state.held_count} + 3'd1;
	assign complete = (cnt >= state.seq_length);

	assign cp_ok = (state.seq_length != utsan_pkg::Len3 || cp_new >= utsan_pkg::CpMin3)
		&& (state.seq_length != utsan_pkg::Len4 || cp_new >= utsan_pkg::CpMin4)
		&& !(cp_new >= utsan_pkg::SurLo && cp_new <= utsan_pkg::SurHi)
		&& (cp_new <= utsan_pkg::CpMax);

	assign cp_space = (cp_new >= utsan_pkg::C1Lo && cp_new <= utsan_pkg::C1Hi)
		|| cp_new == utsan_pkg::LineSep || cp_new == utsan_pkg::ParaSep;

	always_comb begin
		next_state  = state;
		hold_wr     = '0;
		prefix_n    = '0;
		prefix_held = 1'b0;
		tail_en     = 1'b0;
		tail_byte   = utsan_pkg::ChQuest;
		take_fresh  = 1'b0;

		if (!in_seq) begin
			take_fresh = 1'b1;
		end else if (is_cont) begin
			if (complete) begin
				tail_en    = 1'b1;
				next_state = '0;
				if (!cp_ok) begin
					prefix_n  = state.held_count;
					tail_byte = utsan_pkg::ChQuest;
				end else if (cp_space) begin
					tail_byte = utsan_pkg::ChSpace;
				end else begin
					prefix_n    = state.held_count;
					prefix_held = 1'b1;
					tail_byte   = cur_byte;
				end
			end else if (last || state.held_count == 2'(utsan_pkg::HeldMax)) begin
				// message ends inside the sequence, or the held-byte store is full
				prefix_n   = state.held_count;
				tail_en    = 1'b1;
				tail_byte  = utsan_pkg::ChQuest;
				next_state = '0;
			end else begin
				hold_wr.en            = 1'b1;
				hold_wr.idx           = state.held_count;
				next_state.held_count = state.held_count + 2'd1;
				next_state.partial_cp = cp_new;
			end
		end else begin
			// broken sequence: flush held bytes, then decode this byte afresh
			prefix_n   = state.held_count;
			next_state = '0;
			take_fresh = 1'b1;
		end

		if (take_fresh) begin
			tail_en   = fresh_out;
			tail_byte = fresh_byte;
			if (!fresh_out) begin
				hold_wr.en            = 1'b1;
				hold_wr.idx           = 2'd0;
				next_state.held_count = 2'd1;
				next_state.seq_length = fresh_len;
				next_state.partial_cp = fresh_cp;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < utsan_pkg::HeldMax; i++) begin
			pre[i] = prefix_held ? held[i] : utsan_pkg::ChQuest;
		end
		pre[3] = '0;
		for (int i = 0; i < utsan_pkg::MaxOut; i++) begin
			if (3'(i) < {1'b0, prefix_n}) begin
				burst.bytes[i] = pre[i];
			end else if (3'(i) == {1'b0, prefix_n}) begin
				burst.bytes[i] = tail_byte;
			end else begin
				burst.bytes[i] = '0;
			end
		end
		burst.count = {1'b0, prefix_n} + {2'b00, tail_en};
	end

endmodule

[tb/tb.sv]
// Self-checking bench for utf8_text_sanitizer: directed table then random messages.
// Depends on utsan_pkg and the sanitizer RTL; predicts every sanitized byte itself.
`timescale 1ns / 1ps

module tb;

	localparam int DirRows     = 25;
	localparam int RandItems   = 135;
	localparam int QuietLimit  = 1000;  // cycles with no request moving on either side
	localparam int HoldOff     = 90;    // long receiver stall, fills the block
	localparam int HoldAt      = 30;    // output request count at which the stall starts
	localparam int DrainCycles = 20;

	// short names for the typed rows
	localparam logic [7:0] Sp = utsan_pkg::ChSpace;
	localparam logic [7:0] Qm = utsan_pkg::ChQuest;
	localparam logic [7:0] Lb = utsan_pkg::ChLbr;
	localparam logic [7:0] Rb = utsan_pkg::ChRbr;

	// one directed row; typed rows carry their expected bytes, others use the predictor
	typedef struct packed {
		logic            b;
		logic [7:0]      in_b;
		logic            fin;
		logic [2:0]      n;
		logic [0:3][7:0] want;
	} dir_row_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  text_valid  = 1'b0;
	logic                  text_ready;
	utsan_pkg::text_req_t  text_req    = '0;
	logic                  clean_valid;
	logic                  clean_ready = 1'b0;
	utsan_pkg::clean_req_t clean_req;

	// decoder mirror: bytes held for the open sequence and its progress
	logic [7:0]  held_seq [3];
	logic [1:0]  held_n   = '0;
	logic [2:0]  seq_len  = '0;
	logic [20:0] cp_acc   = '0;

	logic [7:0]            burst_q [$];       // bytes released by the current input
	utsan_pkg::clean_req_t clean_due_q [$];   // sanitized bytes still owed by the block
	logic [7:0]            msg_bytes_q [$];   // raw bytes of the message being built

	int sent_n   = 0;
	int rcv_n    = 0;
	int fail_cnt = 0;
	int quiet    = 0;

	// b is the "typed" flag: 1 means the row's expected bytes stand in the table
	dir_row_t dir_tab [0:DirRows-1] = '{
		'{1'b1, 8'h00, 1'b0, 3'd1, {Sp, 24'h0}},                  // lowest control byte
		'{1'b1, 8'h7F, 1'b0, 3'd1, {Sp, 24'h0}},                  // DEL
		'{1'b1, utsan_pkg::ChLt, 1'b0, 3'd1, {Lb, 24'h0}},
		'{1'b1, utsan_pkg::ChGt, 1'b0, 3'd1, {Rb, 24'h0}},
		'{1'b0, 8'h7E, 1'b0, 3'd0, 32'h0},                        // top printable
		'{1'b1, 8'hC1, 1'b0, 3'd1, {Qm, 24'h0}},                  // stray, below 2-byte leads
		'{1'b1, 8'hFF, 1'b0, 3'd1, {Qm, 24'h0}},                  // stray, top byte
		'{1'b1, 8'hC2, 1'b0, 3'd0, 32'h0},                        // U+0085, a C1 control
		'{1'b1, 8'h85, 1'b0, 3'd1, {Sp, 24'h0}},
		'{1'b1, 8'hE2, 1'b0, 3'd0, 32'h0},                        // U+2029 paragraph separator
		'{1'b1, 8'h80, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'hA9, 1'b0, 3'd1, {Sp, 24'h0}},
		'{1'b1, 8'hE0, 1'b0, 3'd0, 32'h0},                        // overlong 3-byte zero
		'{1'b1, 8'h80, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'h80, 1'b0, 3'd3, {Qm, Qm, Qm, 8'h0}},
		'{1'b1, 8'hF4, 1'b0, 3'd0, 32'h0},                        // U+110000, past the top
		'{1'b1, 8'h90, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'h80, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'h80, 1'b0, 3'd4, {Qm, Qm, Qm, Qm}},
		'{1'b0, 8'hF0, 1'b0, 3'd0, 32'h0},                        // broken by a plain 'A'
		'{1'b0, 8'h9F, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'h41, 1'b0, 3'd3, {Qm, Qm, 8'h41, 8'h0}},
		'{1'b0, 8'hE4, 1'b0, 3'd0, 32'h0},                        // message ends mid-sequence
		'{1'b1, 8'hB8, 1'b1, 3'd2, {Qm, Qm, 16'h0}},
		'{1'b1, 8'hF4, 1'b1, 3'd1, {Qm, 24'h0}}                   // lead byte on the last byte
	};

	utf8_text_sanitizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_req    (text_req),
		.clean_valid (clean_valid),
		.clean_ready (clean_ready),
		.clean_req   (clean_req)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void add_burst(logic [7:0] b);
		burst_q = {burst_q, b};
	endfunction

	function automatic void add_msg(logic [7:0] b);
		msg_bytes_q = {msg_bytes_q, b};
	endfunction

	function automatic void drop_seq();
		held_n  = '0;
		seq_len = '0;
		cp_acc  = '0;
	endfunction

	// byte seen outside any sequence: ASCII map, lead byte opens a sequence, rest is '?'
	function automatic void take_fresh(logic [7:0] b, logic last);
		logic [2:0]  len;
		logic [20:0] lead_cp;
		len     = '0;
		lead_cp = '0;
		if (!b[7]) begin
			if (b < utsan_pkg::CtlTop || b == utsan_pkg::ChDel)
				add_burst(utsan_pkg::ChSpace);
			else if (b == utsan_pkg::ChLt)
				add_burst(utsan_pkg::ChLbr);
			else if (b == utsan_pkg::ChGt)
				add_burst(utsan_pkg::ChRbr);
			else
				add_burst(b);
		end else begin
			if (b >= utsan_pkg::Lead2Lo && b <= utsan_pkg::Lead2Hi) begin
				len     = utsan_pkg::Len2;
				lead_cp = {16'h0, b[4:0]};
			end else if (b >= utsan_pkg::Lead3Lo && b <= utsan_pkg::Lead3Hi) begin
				len     = utsan_pkg::Len3;
				lead_cp = {17'h0, b[3:0]};
			end else if (b >= utsan_pkg::Lead4Lo && b <= utsan_pkg::Lead4Hi) begin
				len     = utsan_pkg::Len4;
				lead_cp = {18'h0, b[2:0]};
			end
			// a lead on the last byte can never complete
			if (len == 0 || last) begin
				add_burst(utsan_pkg::ChQuest);
			end else begin
				seq_len     = len;
				cp_acc      = lead_cp;
				held_seq[0] = b;
				held_n      = 2'd1;
			end
		end
	endfunction

	// fills burst_q with the bytes this input releases and advances the mirror
	function automatic void sanitize_byte(logic [7:0] b, logic last);
		logic [20:0] cp;
		int          cnt;
		logic        ok;
		burst_q.delete();
		if (seq_len != 0) begin
			if (b[7:6] == 2'b10) begin
				cp  = {cp_acc[14:0], b[5:0]};
				cnt = held_n + 1;
				if (cnt >= seq_len) begin
					ok = (seq_len != utsan_pkg::Len3 || cp >= utsan_pkg::CpMin3)
						&& (seq_len != utsan_pkg::Len4 || cp >= utsan_pkg::CpMin4)
						&& !(cp >= utsan_pkg::SurLo && cp <= utsan_pkg::SurHi)
						&& cp <= utsan_pkg::CpMax;
					if (!ok) begin
						repeat (cnt) add_burst(utsan_pkg::ChQuest);
					end else if ((cp >= utsan_pkg::C1Lo && cp <= utsan_pkg::C1Hi)
						|| cp == utsan_pkg::LineSep || cp == utsan_pkg::ParaSep) begin
						add_burst(utsan_pkg::ChSpace);
					end else begin
						for (int i = 0; i < held_n; i++)
							add_burst(held_seq[i]);
						add_burst(b);
					end
					drop_seq();
				end else if (last || held_n >= utsan_pkg::HeldMax) begin
					repeat (cnt) add_burst(utsan_pkg::ChQuest);
					drop_seq();
				end else begin
					// continuation held, nothing leaves this step
					held_seq[held_n] = b;
					held_n++;
					cp_acc = cp;
				end
			end else begin
				// sequence broken: held bytes become '?', then the byte starts over
				repeat (held_n) add_burst(utsan_pkg::ChQuest);
				drop_seq();
				take_fresh(b, last);
			end
		end else begin
			take_fresh(b, last);
		end
	endfunction

	// moves burst_q into the owed list; last byte gets run_last and maybe msg_end
	function automatic void queue_expect(logic last);
		utsan_pkg::clean_req_t r;
		foreach (burst_q[i]) begin
			r.out_byte  = burst_q[i];
			r.run_last  = (i == burst_q.size() - 1);
			r.msg_end   = last && r.run_last;
			clean_due_q = {clean_due_q, r};
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what);
		$display("tb: ERROR at %0t: %s", $realtime, what);
		fail_cnt++;
	endtask

	task automatic check_clean(utsan_pkg::clean_req_t got);
		utsan_pkg::clean_req_t want;
		if (clean_due_q.size() == 0) begin
			report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
		end else begin
			want = clean_due_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
			if (got.msg_end !== want.msg_end)
				report_mismatch($sformatf("msg_end %b, want %b", got.msg_end, want.msg_end));
		end
	endtask

	// Everything is driven at the rising edge, so at the falling edge the channels
	// are settled: a request seen here moves at the next rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (clean_valid && clean_ready)
				check_clean(clean_req);
			if ((text_valid && text_ready) || (clean_valid && clean_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QuietLimit) begin
				$display("tb: no request moved for %0d cycles", QuietLimit);
				$display("utf8_text_sanitizer: mismatch");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// one input request; runs of back-to-back requests alternate with random gaps
	task automatic send_text(logic [7:0] b, logic last);
		int gap;
		gap = (sent_n % 48 < 16) ? 0 : int'($urandom_range(0, 6));
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_req   <= '{in_byte: b, in_end: last};
		do @(negedge clk); while (!text_ready);
		@(posedge clk);
		sent_n++;
		sanitize_byte(b, last);
	endtask

	// UTF-8 encoding of cp in len bytes; overlong forms come out when cp is small
	task automatic add_cp(logic [20:0] cp, int len);
		case (len)
			2: begin
				add_msg({3'b110, cp[10:6]});
				add_msg({2'b10, cp[5:0]});
			end
			3: begin
				add_msg({4'b1110, cp[15:12]});
				add_msg({2'b10, cp[11:6]});
				add_msg({2'b10, cp[5:0]});
			end
			default: begin
				add_msg({5'b11110, cp[20:18]});
				add_msg({2'b10, cp[17:12]});
				add_msg({2'b10, cp[11:6]});
				add_msg({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// Random message: mostly well-formed text of every width, plus the forms the
	// block must reject (surrogates, overlong, past U+10FFFF), cut-off sequences
	// and raw noise bytes.
	task automatic build_message();
		int ntok;
		int kind;
		int len;
		int cut;
		msg_bytes_q.delete();
		ntok = $urandom_range(1, 6);
		repeat (ntok) begin
			kind = $urandom_range(0, 15);
			case (kind)
				0, 1, 2, 3, 4: add_msg(8'($urandom_range(0, 127)));
				5, 6, 7:       add_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
				8, 9:          add_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
				10:            add_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
				11: begin
					case ($urandom_range(0, 2))
						0:       add_cp(21'($urandom_range(utsan_pkg::C1Lo, utsan_pkg::C1Hi)), 2);
						1:       add_cp(utsan_pkg::LineSep, 3);
						default: add_cp(utsan_pkg::ParaSep, 3);
					endcase
				end
				12: begin
					case ($urandom_range(0, 3))
						0:       add_cp(21'($urandom_range(utsan_pkg::SurLo, utsan_pkg::SurHi)), 3);
						1:       add_cp(21'($urandom_range(0, 21'h7FF)), 3);
						2:       add_cp(21'($urandom_range(0, 21'hFFFF)), 4);
						default: add_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
					endcase
				end
				13: begin
					// truncated sequence; whatever follows breaks it, or the message ends
					len = $urandom_range(2, 4);
					if (len == 2)
						add_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
					else if (len == 3)
						add_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
					else
						add_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
					cut = $urandom_range(1, len - 1);
					repeat (cut) void'(msg_bytes_q.pop_back());
				end
				default: add_msg(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// receiver: random stalls per request, calm stretches, and one long hold-off
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rcv_n == HoldAt)
				stall = HoldOff;
			else
				stall = (rcv_n % 40 < 12) ? 0 : int'($urandom_range(0, 6));
			if (stall > 0) begin
				clean_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			clean_ready <= 1'b1;
			do @(negedge clk); while (!clean_valid);
			@(posedge clk);
			rcv_n++;
		end
	end

	initial begin
		int last_i;
		held_seq[0] = '0;
		held_seq[1] = '0;
		held_seq[2] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table: typed rows replace the predicted bytes with their own
		foreach (dir_tab[r]) begin
			send_text(dir_tab[r].in_b, dir_tab[r].fin);
			if (dir_tab[r].b) begin
				burst_q.delete();
				for (int k = 0; k < dir_tab[r].n; k++)
					add_burst(dir_tab[r].want[k]);
			end
			queue_expect(dir_tab[r].fin);
		end

		// random messages, each closed by in_end on its last byte
		while (sent_n < DirRows + RandItems) begin
			build_message();
			last_i = msg_bytes_q.size() - 1;
			foreach (msg_bytes_q[k]) begin
				send_text(msg_bytes_q[k], k == last_i);
				queue_expect(k == last_i);
			end
		end
		text_valid <= 1'b0;

		// let the block drain, then a short quiet window for stray output
		while (clean_due_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_cnt == 0)
			$display("utf8_text_sanitizer: match");
		else
			$display("utf8_text_sanitizer: mismatch");
		$finish;
	end

endmodule

[sim.f]
src/utsan_pkg.sv
src/utsan_step.sv
src/utf8_text_sanitizer.sv
tb/tb.sv
